// File: hdl/crce_pkg.sv
// ----------------------------------------------------------------------------
// crce_pkg
// shared types, register indexes and helper functions of the crc engine
// ----------------------------------------------------------------------------
package crce_pkg;

    localparam int CRC_BITS      = 32;
    localparam int DEF_MAX_WIDTH = 32;
    localparam int MIN_WIDTH     = 8;
    localparam int SHIFT_BITS    = 5;
    localparam int IDX_BITS      = 3;

    localparam logic [IDX_BITS-1:0] REG_CRC_WIDTH   = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_POLYNOMIAL  = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_REFLECT_IN  = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_REFLECT_OUT = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_FINAL_XOR   = 3'd4;

    localparam logic [5:0]          RST_CRC_WIDTH   = 6'd16;
    localparam logic [CRC_BITS-1:0] RST_POLYNOMIAL  = 32'h0000_8005;

    typedef struct packed {
        logic [5:0]          crc_width;
        logic [CRC_BITS-1:0] polynomial;
        logic                reflect_in;
        logic                reflect_out;
        logic [CRC_BITS-1:0] final_xor;
    } crce_cfg_t;

    typedef struct packed {
        logic [7:0]          data_byte;
        logic                first_byte;
        logic                last_byte;
        logic [CRC_BITS-1:0] seed;
    } crce_item_t;

    function automatic logic [7:0] bitrev8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[i] = v[7-i];
        end
        return r;
    endfunction

    function automatic logic [CRC_BITS-1:0] bitrev32(input logic [CRC_BITS-1:0] v);
        logic [CRC_BITS-1:0] r;
        for (int i = 0; i < CRC_BITS; i++)
        begin
            r[i] = v[CRC_BITS-1-i];
        end
        return r;
    endfunction

    // left shift that places a width-w register at the top of 32 bits
    function automatic logic [SHIFT_BITS-1:0] width_shift(input logic [5:0] cw,
                                                          input logic [5:0] lim);
        logic [5:0] w;
        logic [5:0] s;
        w = cw;
        if (w < 6'(MIN_WIDTH))
        begin
            w = 6'(MIN_WIDTH);
        end
        if (w > lim)
        begin
            w = lim;
        end
        s = 6'(CRC_BITS) - w;
        return s[SHIFT_BITS-1:0];
    endfunction

endpackage

// File: hdl/crce_ifs.sv
// ----------------------------------------------------------------------------
// crce channel interfaces
// message, result and configuration channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface crce_msg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic [31:0] seed;

    modport source (output valid, data_byte, first_byte, last_byte, seed, input ready);
    modport sink   (input valid, data_byte, first_byte, last_byte, seed, output ready);
endinterface

interface crce_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] crc_value;

    modport source (output valid, crc_value, input ready);
    modport sink   (input valid, crc_value, output ready);
endinterface

interface crce_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/crce_front.sv
// ----------------------------------------------------------------------------
// crce_front
// accepts message bytes, applies input reflection and queues them (2 deep)
// ----------------------------------------------------------------------------
module crce_front
    import crce_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  crce_cfg_t   cfg_regs,
    crce_msg_if.sink    msg,
    output logic        q_valid,
    output crce_item_t  q_item,
    input  logic        q_ready
);

    crce_item_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;
    crce_item_t item_in;

    assign msg.ready = (count_reg != 2'd2);
    assign q_valid   = (count_reg != 2'd0);
    assign q_item    = mem[rd_ptr_reg];
    assign push      = msg.valid && msg.ready;
    assign pop       = q_valid && q_ready;

    always_comb
    begin
        item_in.data_byte  = cfg_regs.reflect_in ? bitrev8(msg.data_byte) : msg.data_byte;
        item_in.first_byte = msg.first_byte;
        item_in.last_byte  = msg.last_byte;
        item_in.seed       = msg.seed;
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hdl/crce_back.sv
// ----------------------------------------------------------------------------
// crce_back
// byte-wide crc update in top-aligned form, result shaping and output register
// ----------------------------------------------------------------------------
module crce_back
    import crce_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  crce_cfg_t             cfg_regs,
    input  logic [SHIFT_BITS-1:0] shift,
    input  logic                  q_valid,
    input  crce_item_t            q_item,
    output logic                  q_ready,
    crce_res_if.source            res
);

    logic [CRC_BITS-1:0] crc_reg, crc_next;
    logic                a_valid_reg, a_valid_next;
    logic [CRC_BITS-1:0] a_al_reg;
    logic                o_valid_reg, o_valid_next;
    logic [CRC_BITS-1:0] o_crc_reg, o_crc_next;
    logic                o_ready, a_ready, step;
    logic [CRC_BITS-1:0] poly_al, x_al, shaped, mask;

    assign o_ready = !o_valid_reg || res.ready;
    assign a_ready = !a_valid_reg || o_ready;
    assign q_ready = !q_item.last_byte || a_ready;
    assign step    = q_valid && q_ready;

    assign poly_al = cfg_regs.polynomial << shift;
    assign mask    = {CRC_BITS{1'b1}} >> shift;

    // eight shift steps on the top-aligned register
    always_comb
    begin
        x_al = (q_item.first_byte ? q_item.seed : crc_reg) << shift;
        x_al = x_al ^ {q_item.data_byte, {(CRC_BITS-8){1'b0}}};
        for (int k = 0; k < 8; k++)
        begin
            x_al = x_al[CRC_BITS-1] ? ((x_al << 1) ^ poly_al) : (x_al << 1);
        end
        crc_next = step ? (x_al >> shift) : crc_reg;
    end

    always_comb
    begin
        a_valid_next = a_ready ? (q_valid && q_item.last_byte) : a_valid_reg;
        shaped       = cfg_regs.reflect_out ? bitrev32(a_al_reg) : (a_al_reg >> shift);
        o_valid_next = o_ready ? a_valid_reg : o_valid_reg;
        o_crc_next   = (shaped ^ cfg_regs.final_xor) & mask;
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && step)
        begin
            a_al_reg <= x_al;
        end
        if (o_ready && a_valid_reg)
        begin
            o_crc_reg <= o_crc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg     <= '0;
            a_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg     <= crc_next;
            a_valid_reg <= a_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    assign res.valid     = o_valid_reg;
    assign res.crc_value = o_crc_reg;

endmodule

// File: hdl/parameterized_crc_engine.sv
// ----------------------------------------------------------------------------
// parameterized_crc_engine
// byte-serial crc of configurable width, polynomial, reflection and final xor
//
//   channel | dir | payload                                   | transaction
//   msg     | in  | data_byte, first_byte, last_byte, seed    | valid & ready
//   res     | out | crc_value                                 | valid & ready
//   cfg     | in  | index, data                               | valid & ready
//
// one byte per cycle while the queue has room; the front queue and the output
// stages keep the stream moving while a result waits. the 8-step register update
// is combinational. a last byte passes the queue, the update into the aligned
// register, then shaping into the output register, before reaching the port.
// reset clears the crc register and loads the default configuration.
// a stalled result holds the back only on a last byte; other bytes flow on.
// ----------------------------------------------------------------------------
module parameterized_crc_engine
    import crce_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    crce_cfg_if.sink   cfg,
    crce_msg_if.sink   msg,
    crce_res_if.source res
);

    localparam int WIDTH_LIMIT = (MAX_WIDTH < CRC_BITS) ? MAX_WIDTH : CRC_BITS;

    crce_cfg_t             cfg_reg, cfg_next;
    logic [SHIFT_BITS-1:0] shift;
    logic                  q_valid, q_ready;
    crce_item_t            q_item;

    assign cfg.ready = 1'b1;
    assign shift     = width_shift(cfg_reg.crc_width, 6'(WIDTH_LIMIT));

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_CRC_WIDTH:   cfg_next.crc_width   = cfg.data[5:0];
                REG_POLYNOMIAL:  cfg_next.polynomial  = cfg.data;
                REG_REFLECT_IN:  cfg_next.reflect_in  = cfg.data[0];
                REG_REFLECT_OUT: cfg_next.reflect_out = cfg.data[0];
                REG_FINAL_XOR:   cfg_next.final_xor   = cfg.data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.crc_width   <= RST_CRC_WIDTH;
            cfg_reg.polynomial  <= RST_POLYNOMIAL;
            cfg_reg.reflect_in  <= 1'b1;
            cfg_reg.reflect_out <= 1'b1;
            cfg_reg.final_xor   <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    crce_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_regs (cfg_reg),
        .msg      (msg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_ready  (q_ready)
    );

    crce_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_regs (cfg_reg),
        .shift    (shift),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_ready  (q_ready),
        .res      (res)
    );

    // a full front queue always has work for the back
    assert property (@(posedge clk) disable iff (!rst_n) !msg.ready |-> q_valid)
        else $error("front stalls with an empty queue");

    // the back holds a queued byte only when it ends a message
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && !q_ready) |-> q_item.last_byte)
        else $error("back stalls on a byte that gives no result");

    // a held queue entry stays until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && !q_ready) |=> (q_valid && $stable(q_item)))
        else $error("queued byte lost while back stalled");

endmodule

// File: test/tb_parameterized_crc_engine.sv
// ----------------------------------------------------------------------------
// tb_parameterized_crc_engine
// self-checking bench for the byte-serial crc engine: a local model of the
// crc register predicts every result, which is compared against the result
// channel in order. directed cases cover the default setup, width limits,
// operand masking, mixed reflection and width changes inside a message;
// random traffic runs under several settings and handshake idling patterns,
// and a long result stall checks that the block holds its input.
// ----------------------------------------------------------------------------
module tb_parameterized_crc_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import crce_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int MAX_W          = DEF_MAX_WIDTH;
    localparam int WIDTH_LIM      = (MAX_W < CRC_BITS) ? MAX_W : CRC_BITS;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int CHUNK_BYTES    = 56;
    localparam int HOLD_CYCLES    = 300;

    logic clk = 1'b0;
    logic rst_n;

    crce_cfg_if cfg_if ();
    crce_msg_if msg_if ();
    crce_res_if res_if ();

    parameterized_crc_engine #(.MAX_WIDTH(MAX_W)) u_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_if),
        .msg   (msg_if),
        .res   (res_if)
    );

    // model of the engine configuration and crc register
    logic [5:0]  cfg_width    = RST_CRC_WIDTH;
    logic [31:0] cfg_poly     = RST_POLYNOMIAL;
    logic        cfg_refl_in  = 1'b1;
    logic        cfg_refl_out = 1'b1;
    logic [31:0] cfg_xor      = '0;
    logic [31:0] crc_reg      = '0;

    logic [31:0] pending_crcs[$];
    int          mismatch_count = 0;
    int          src_idle_pct   = 0;
    int          sink_stall_pct = 0;
    int          stall_left     = 0;
    int          quiet_cycles   = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic logic [63:0] mirror_bits(input logic [63:0] v, input int n);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < n; i++)
        begin
            r = (r << 1) | v[i];
        end
        return r;
    endfunction

    task automatic advance_crc(input crce_item_t it);
        int          w;
        logic [63:0] mask;
        logic [63:0] poly;
        logic [63:0] acc;
        logic [63:0] in_bits;
        logic [63:0] crc_out;
        logic        top;
        w = int'(cfg_width);
        if (w < MIN_WIDTH)
        begin
            w = MIN_WIDTH;
        end
        if (w > WIDTH_LIM)
        begin
            w = WIDTH_LIM;
        end
        mask = (64'd1 << w) - 64'd1;
        poly = {32'd0, cfg_poly} & mask;
        acc  = {32'd0, crc_reg} & mask;
        if (it.first_byte)
        begin
            acc = {32'd0, it.seed} & mask;
        end
        in_bits = {56'd0, it.data_byte};
        if (cfg_refl_in)
        begin
            in_bits = mirror_bits(in_bits, 8);
        end
        acc ^= in_bits << (w - 8);
        for (int k = 0; k < 8; k++)
        begin
            top = acc[w-1];
            acc = (acc << 1) & mask;
            if (top)
            begin
                acc ^= poly;
            end
        end
        crc_reg = acc[31:0];
        if (it.last_byte)
        begin
            crc_out = cfg_refl_out ? mirror_bits(acc, w) : acc;
            crc_out = (crc_out ^ {32'd0, cfg_xor}) & mask;
            pending_crcs.push_back(crc_out[31:0]);
        end
    endtask

    task automatic send_byte(input logic [7:0] data, input logic is_first,
                             input logic is_last, input logic [31:0] seed);
        crce_item_t it;
        it.data_byte  = data;
        it.first_byte = is_first;
        it.last_byte  = is_last;
        it.seed       = seed;
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            msg_if.valid <= 1'b0;
            @(negedge clk);
        end
        msg_if.valid      <= 1'b1;
        msg_if.data_byte  <= it.data_byte;
        msg_if.first_byte <= it.first_byte;
        msg_if.last_byte  <= it.last_byte;
        msg_if.seed       <= it.seed;
        @(posedge clk);
        while (!msg_if.ready)
        begin
            @(posedge clk);
        end
        advance_crc(it);
    endtask

    task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        @(posedge clk);
        while (!cfg_if.ready)
        begin
            @(posedge clk);
        end
        case (idx)
            REG_CRC_WIDTH:   cfg_width    = data[5:0];
            REG_POLYNOMIAL:  cfg_poly     = data;
            REG_REFLECT_IN:  cfg_refl_in  = data[0];
            REG_REFLECT_OUT: cfg_refl_out = data[0];
            REG_FINAL_XOR:   cfg_xor      = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic set_config(input logic [31:0] width, input logic [31:0] poly,
                              input logic [31:0] refl_in, input logic [31:0] refl_out,
                              input logic [31:0] xor_val);
        write_reg(REG_CRC_WIDTH, width);
        write_reg(REG_POLYNOMIAL, poly);
        write_reg(REG_REFLECT_IN, refl_in);
        write_reg(REG_REFLECT_OUT, refl_out);
        write_reg(REG_FINAL_XOR, xor_val);
    endtask

    // stop offering bytes, collect every result, then let the pipeline settle
    task automatic drain;
        @(negedge clk);
        msg_if.valid <= 1'b0;
        while (pending_crcs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_directed_defaults;
        // register is zero after reset when no first byte is given
        send_byte(8'hA5, 1'b0, 1'b1, 32'h0);
        for (int i = 0; i < 9; i++)
        begin
            send_byte(8'(8'h31 + i), i == 0, i == 8, 32'h0);
        end
        // continues from the finished register, seed ignored
        send_byte(8'h00, 1'b0, 1'b1, 32'hFFFF_FFFF);
        send_byte(8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
        send_byte(8'h00, 1'b1, 1'b1, 32'h0000_0000);
        drain;
    endtask

    task automatic test_width_limits;
        set_config(MIN_WIDTH, 32'h0000_0007, 0, 0, 32'h0);
        send_byte(8'h80, 1'b1, 1'b1, 32'hFFFF_FF00);
        drain;
        set_config(WIDTH_LIM, 32'h04C1_1DB7, 1, 1, 32'hFFFF_FFFF);
        send_byte(8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
        drain;
        // below the minimum and above the maximum width, mixed reflection, wide operands
        set_config(0, 32'hFFFF_FFFF, 0, 1, 32'hFFFF_FFFF);
        send_byte(8'h01, 1'b1, 1'b1, 32'hDEAD_BEEF);
        drain;
        set_config(63, 32'h0, 1, 0, 32'h0);
        send_byte(8'h7E, 1'b1, 1'b1, 32'h8000_0001);
        drain;
        // only the low bits of the width and reflect registers count
        set_config(32'hFFFF_FFC9, 32'h0000_0123, 32'hFFFF_FFFE, 32'h0000_0003,
                   32'hAAAA_5555);
        send_byte(8'hC3, 1'b1, 1'b1, 32'h5555_AAAA);
        drain;
        // width change inside a message
        write_reg(REG_CRC_WIDTH, WIDTH_LIM);
        send_byte(8'h5A, 1'b1, 1'b0, 32'h1234_5678);
        drain;
        write_reg(REG_CRC_WIDTH, 12);
        send_byte(8'h3C, 1'b0, 1'b1, 32'h0);
        drain;
        // writes to unused indexes change nothing
        for (int idx = REG_FINAL_XOR + 1; idx < (1 << IDX_BITS); idx++)
        begin
            write_reg(IDX_BITS'(idx), 32'hFFFF_FFFF);
        end
        send_byte(8'h96, 1'b1, 1'b1, 32'h0F0F_0F0F);
        drain;
    endtask

    task automatic test_random_traffic;
        int          src_pcts[4]  = '{0, 66, 0, 23};
        int          sink_pcts[4] = '{0, 0, 66, 23};
        int          sent;
        int          len;
        logic [31:0] width;
        logic [31:0] poly;
        logic [31:0] xor_val;
        for (int phase = 0; phase < 4; phase++)
        begin
            src_idle_pct   = src_pcts[phase];
            sink_stall_pct = sink_pcts[phase];
            for (int chunk = 0; chunk < 4; chunk++)
            begin
                case ($urandom_range(5))
                    0:       width = MIN_WIDTH;
                    1:       width = WIDTH_LIM;
                    2:       width = 16;
                    3:       width = $urandom_range(MIN_WIDTH, WIDTH_LIM);
                    default: width = $urandom;
                endcase
                poly = $urandom;
                if ($urandom_range(1))
                begin
                    poly[0] = 1'b1;
                end
                case ($urandom_range(2))
                    0:       xor_val = '0;
                    1:       xor_val = '1;
                    default: xor_val = $urandom;
                endcase
                set_config(width, poly, $urandom, $urandom, xor_val);
                sent = 0;
                while (sent < CHUNK_BYTES)
                begin
                    if ($urandom_range(99) < 85)
                    begin
                        len = ($urandom_range(9) == 0) ? $urandom_range(9, 24)
                                                       : $urandom_range(1, 8);
                        for (int i = 0; i < len; i++)
                        begin
                            send_byte(8'($urandom), i == 0, i == len - 1, $urandom);
                        end
                        sent += len;
                    end
                    else
                    begin
                        send_byte(8'($urandom), 1'($urandom_range(1)),
                                  1'($urandom_range(1)), $urandom);
                        sent++;
                    end
                end
                drain;
            end
        end
    endtask

    task automatic test_backpressure;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        set_config(WIDTH_LIM, 32'h04C1_1DB7, 1, 1, 32'hFFFF_FFFF);
        stall_left = HOLD_CYCLES;
        repeat (40) send_byte(8'($urandom), 1'b1, 1'b1, $urandom);
        drain;
    endtask

    // result side ready, with random stalls and long hold-offs
    initial
    begin
        res_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                res_if.ready <= 1'b0;
                stall_left = stall_left - 1;
            end
            else
            begin
                res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        logic [31:0] want_crc;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (pending_crcs.size() == 0)
            begin
                $display("%0t: unexpected crc transaction, expected none, actual 0x%08h",
                         $time, res_if.crc_value);
                mismatch_count++;
            end
            else
            begin
                want_crc = pending_crcs.pop_front();
                if (res_if.crc_value !== want_crc)
                begin
                    $display("%0t: crc_value mismatch, expected 0x%08h, actual 0x%08h",
                             $time, want_crc, res_if.crc_value);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((msg_if.valid && msg_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog, no transaction for %0d cycles", $time, quiet_cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        msg_if.valid      = 1'b0;
        msg_if.data_byte  = '0;
        msg_if.first_byte = 1'b0;
        msg_if.last_byte  = 1'b0;
        msg_if.seed       = '0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = '0;
        cfg_if.data       = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_defaults;
        test_width_limits;
        test_random_traffic;
        test_backpressure;

        if (mismatch_count == 0 && pending_crcs.size() == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
